// ===== rtl/core/sha1_pkg.sv =====
// sha1_pkg: shared types and constants for the sha-1 hash engine
// no dependencies; imported by every module of the engine
`default_nettype none

package sha1_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] IV_H0 = 32'h6745_2301;
  localparam logic [31:0] IV_H1 = 32'hefcd_ab89;
  localparam logic [31:0] IV_H2 = 32'h98ba_dcfe;
  localparam logic [31:0] IV_H3 = 32'h1032_5476;
  localparam logic [31:0] IV_H4 = 32'hc3d2_e1f0;

  localparam logic [31:0] K_R0 = 32'h5a82_7999;
  localparam logic [31:0] K_R1 = 32'h6ed9_eba1;
  localparam logic [31:0] K_R2 = 32'h8f1b_bcdc;
  localparam logic [31:0] K_R3 = 32'hca62_c1d6;

  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // one message schedule word on its way from front to back
  typedef struct packed {
    logic [31:0] word;
    logic        final_word;
  } word_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/sha1_front.sv =====
// sha1_front: takes message words, applies padding and length, feeds the queue
// depends on sha1_pkg
`default_nettype none

module sha1_front
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  valid_bytes,
  input  wire logic        last,
  input  wire logic        data_valid,
  output logic             data_ready,
  input  wire logic        q_full,
  output logic             q_push,
  output word_entry_t      q_entry
);

  typedef enum logic [1:0] {F_TAKE, F_PAD, F_FILL, F_LEN_LO} front_state_t;

  front_state_t state;
  logic [3:0]   pos;
  logic [60:0]  total;
  logic [2:0]   nb_sat;
  logic [63:0]  bit_len;
  logic [31:0]  last_word_padded;

  // keep the valid bytes of a short final word and put the pad byte after them
  function automatic logic [31:0] pad_short(input logic [31:0] d, input logic [2:0] nb);
    logic [31:0] r;
    case (nb)
      3'd0:    r = {PAD_BYTE, 24'h0};
      3'd1:    r = {d[31:24], PAD_BYTE, 16'h0};
      3'd2:    r = {d[31:16], PAD_BYTE, 8'h0};
      3'd3:    r = {d[31:8], PAD_BYTE};
      default: r = d;
    endcase
    return r;
  endfunction

  assign nb_sat           = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
  assign bit_len          = {total, 3'b000};
  assign last_word_padded = pad_short(data_word, nb_sat);
  assign data_ready       = (state == F_TAKE) && !q_full;

  always_comb begin
    q_push  = 1'b0;
    q_entry = '{word: 32'h0, final_word: 1'b0};
    case (state)
      F_TAKE: begin
        q_push        = data_valid && !q_full;
        q_entry.word  = (last && nb_sat != 3'd4) ? last_word_padded : data_word;
      end
      F_PAD: begin
        q_push        = !q_full;
        q_entry.word  = {PAD_BYTE, 24'h0};
      end
      F_FILL: begin
        q_push        = !q_full;
        q_entry.word  = (pos == 4'd14) ? bit_len[63:32] : 32'h0;
      end
      F_LEN_LO: begin
        q_push             = !q_full;
        q_entry.word       = bit_len[31:0];
        q_entry.final_word = 1'b1;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_TAKE;
      pos   <= 4'd0;
      total <= 61'd0;
    end else begin
      if (q_push) begin
        pos <= pos + 4'd1;
      end
      case (state)
        F_TAKE: begin
          if (q_push) begin
            if (!last) begin
              total <= total + 61'd4;
            end else begin
              total <= total + {58'd0, nb_sat};
              state <= (nb_sat == 3'd4) ? F_PAD : F_FILL;
            end
          end
        end
        F_PAD: begin
          if (q_push) begin
            state <= F_FILL;
          end
        end
        F_FILL: begin
          if (q_push && pos == 4'd14) begin
            state <= F_LEN_LO;
          end
        end
        F_LEN_LO: begin
          // the low length word sits in slot 15, so pos wraps to zero here
          if (q_push) begin
            state <= F_TAKE;
            total <= 61'd0;
          end
        end
        default: begin
          state <= F_TAKE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_queue.sv =====
// sha1_queue: short first-in first-out queue of schedule words
// depends on sha1_pkg
`default_nettype none

module sha1_queue
  import sha1_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire word_entry_t push_entry,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output word_entry_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  word_entry_t       slots [DEPTH];
  logic [PW-1:0]     wptr;
  logic [PW-1:0]     rptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_back.sv =====
// sha1_back: 80-round sha-1 compression, one round per cycle unless waiting on the queue, and digest output
// depends on sha1_pkg
`default_nettype none

module sha1_back
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire word_entry_t q_head,
  output logic             q_pop,
  output logic [31:0]      digest_word,
  output logic             last_word,
  output logic             digest_valid,
  input  wire logic        digest_ready
);

  typedef enum logic [1:0] {B_ROUND, B_ADD, B_EMIT} back_state_t;

  back_state_t state;
  logic [6:0]  round;
  logic [2:0]  emit_idx;
  logic        final_blk;
  logic [31:0] a, b, c, d, e;
  logic [31:0] h [5];
  logic [31:0] w [16];
  logic [31:0] wt;
  logic [31:0] w_mix;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;
  logic        step;
  logic [31:0] h_sum [5];

  // w[15] holds w(t-1), w[0] holds w(t-16)
  assign w_mix = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign wt    = (round < 7'd16) ? q_head.word : {w_mix[30:0], w_mix[31]};
  assign q_pop = (state == B_ROUND) && (round < 7'd16) && q_valid;
  assign step  = (state == B_ROUND) && ((round >= 7'd16) || q_valid);

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_R0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K_R1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_R2;
    end else begin
      f = b ^ c ^ d;
      k = K_R3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + wt + k;
  end

  assign h_sum[0] = h[0] + a;
  assign h_sum[1] = h[1] + b;
  assign h_sum[2] = h[2] + c;
  assign h_sum[3] = h[3] + d;
  assign h_sum[4] = h[4] + e;

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= wt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_ROUND;
      round        <= 7'd0;
      emit_idx     <= 3'd0;
      final_blk    <= 1'b0;
      digest_valid <= 1'b0;
      last_word    <= 1'b0;
      digest_word  <= 32'h0;
      h[0] <= IV_H0; h[1] <= IV_H1; h[2] <= IV_H2; h[3] <= IV_H3; h[4] <= IV_H4;
      a <= IV_H0; b <= IV_H1; c <= IV_H2; d <= IV_H3; e <= IV_H4;
    end else begin
      if (digest_valid && digest_ready && state != B_EMIT) begin
        digest_valid <= 1'b0;
      end
      case (state)
        B_ROUND: begin
          if (step) begin
            a <= tmp;
            b <= a;
            c <= {b[1:0], b[31:2]};
            d <= c;
            e <= d;
            if (round == 7'd15) begin
              final_blk <= q_head.final_word;
            end
            if (round == 7'd79) begin
              state <= B_ADD;
              round <= 7'd0;
            end else begin
              round <= round + 7'd1;
            end
          end
        end
        B_ADD: begin
          for (int i = 0; i < 5; i++) begin
            h[i] <= h_sum[i];
          end
          a <= h_sum[0]; b <= h_sum[1]; c <= h_sum[2]; d <= h_sum[3]; e <= h_sum[4];
          emit_idx <= 3'd0;
          state    <= final_blk ? B_EMIT : B_ROUND;
        end
        B_EMIT: begin
          if (!digest_valid || digest_ready) begin
            digest_valid <= 1'b1;
            digest_word  <= h[emit_idx];
            last_word    <= (emit_idx == 3'd4);
            emit_idx     <= emit_idx + 3'd1;
            if (emit_idx == 3'd4) begin
              h[0] <= IV_H0; h[1] <= IV_H1; h[2] <= IV_H2; h[3] <= IV_H3; h[4] <= IV_H4;
              a <= IV_H0; b <= IV_H1; c <= IV_H2; d <= IV_H3; e <= IV_H4;
              final_blk <= 1'b0;
              state     <= B_ROUND;
            end
          end
        end
        default: begin
          state <= B_ROUND;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sha1_hash_engine_top.sv =====
// sha1_hash_engine_top: streaming sha-1 digest engine
// depends on sha1_pkg, sha1_front, sha1_queue, sha1_back
//
// input channel: data_word (big-endian, first byte in bits 31..24), valid_bytes
// and last, with data_valid / data_ready. valid_bytes counts only on the last
// word; values above four act as four.
// output channel: five digest_word transfers per message, H0 first, with
// last_word high on the fifth, under digest_valid / digest_ready.
// the front pads the message and appends the 64-bit bit length; a small queue
// carries schedule words to the back, which runs one sha-1 round per cycle
// unless it waits on the queue for a schedule word. each 16-word block takes
// 80 rounds and a chaining add, all in the single round unit.
// the first 16 rounds consume queued words, so the front may run ahead by the
// queue depth while the back works.
// reset clears all control state and loads the initial chaining vector.
// a stalled receiver holds the digest word in the output register; the back
// then waits, the queue fills and data_ready drops.
`default_nettype none

module sha1_hash_engine_top
  import sha1_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  valid_bytes,
  input  wire logic        last,
  input  wire logic        data_valid,
  output logic             data_ready,
  output logic [31:0]      digest_word,
  output logic             last_word,
  output logic             digest_valid,
  input  wire logic        digest_ready
);

  word_entry_t push_entry;
  word_entry_t head;
  logic        push;
  logic        full;
  logic        pop;
  logic        not_empty;

  sha1_front u_front (
    .clk         (clk),
    .rst         (rst),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .last        (last),
    .data_valid  (data_valid),
    .data_ready  (data_ready),
    .q_full      (full),
    .q_push      (push),
    .q_entry     (push_entry)
  );

  sha1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  sha1_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (not_empty),
    .q_head       (head),
    .q_pop        (pop),
    .digest_word  (digest_word),
    .last_word    (last_word),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready)
  );

endmodule

`default_nettype wire

// ===== rtl/core/sha1_checker.sv =====
// sha1_checker: port-level checks for the sha-1 engine, bound to the top level
// depends on sha1_hash_engine_top
`default_nettype none

module sha1_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        last,
  input wire logic        data_valid,
  input wire logic        data_ready,
  input wire logic [31:0] digest_word,
  input wire logic        last_word,
  input wire logic        digest_valid,
  input wire logic        digest_ready
);

  logic [2:0] out_cnt;
  logic [7:0] pending;
  logic       in_last_xfer;
  logic       out_xfer;

  assign in_last_xfer = data_valid && data_ready && last;
  assign out_xfer     = digest_valid && digest_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 3'd0;
      pending <= 8'd0;
    end else begin
      if (out_xfer) begin
        out_cnt <= last_word ? 3'd0 : out_cnt + 3'd1;
      end
      case ({in_last_xfer, out_xfer && last_word})
        2'b10:   pending <= pending + 8'd1;
        2'b01:   pending <= pending - 8'd1;
        default: pending <= pending;
      endcase
    end
  end

  // held output transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_ready |=> digest_valid && $stable(digest_word)
      && $stable(last_word))
    else $error("digest payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !digest_valid)
    else $error("digest valid right after reset");

  a_five_words: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (last_word == (out_cnt == 3'd4)))
    else $error("last_word not on the fifth digest word");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> pending != 8'd0)
    else $error("digest shown with no finished message");

endmodule

bind sha1_hash_engine_top sha1_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .last         (last),
  .data_valid   (data_valid),
  .data_ready   (data_ready),
  .digest_word  (digest_word),
  .last_word    (last_word),
  .digest_valid (digest_valid),
  .digest_ready (digest_ready)
);

`default_nettype wire

// ===== tb/sha1_hash_engine_top_tb.sv =====
// sha1_hash_engine_top_tb: self-checking bench for the streaming sha-1 engine
// depends on sha1_hash_engine_top; predicts each digest in-bench
// drives directed and random messages under random stalls on both channels, except in the back-to-back test
`timescale 1ns / 100ps

module sha1_hash_engine_top_tb;

  localparam logic [31:0] INIT_H0 = 32'h6745_2301;
  localparam logic [31:0] INIT_H1 = 32'hefcd_ab89;
  localparam logic [31:0] INIT_H2 = 32'h98ba_dcfe;
  localparam logic [31:0] INIT_H3 = 32'h1032_5476;
  localparam logic [31:0] INIT_H4 = 32'hc3d2_e1f0;
  localparam logic [31:0] ROUND_K0 = 32'h5a82_7999;
  localparam logic [31:0] ROUND_K1 = 32'h6ed9_eba1;
  localparam logic [31:0] ROUND_K2 = 32'h8f1b_bcdc;
  localparam logic [31:0] ROUND_K3 = 32'hca62_c1d6;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [2:0]  FULL_WORD = 3'd4;
  localparam int unsigned LENGTH_SLOT = 14;
  localparam int unsigned STALL_PCT = 25;
  localparam int unsigned HANG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [31:0] word;
    logic        fin;
  } digest_entry_t;

  logic        clk = 1'b0;
  logic        rst;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        last;
  logic        data_valid;
  logic        data_ready;
  logic [31:0] digest_word;
  logic        last_word;
  logic        digest_valid;
  logic        digest_ready;

  logic [31:0]   chain_h [5];
  logic [31:0]   msg_blk [16];
  int unsigned   blk_fill;
  logic [60:0]   msg_bytes;
  digest_entry_t digest_q [$];

  bit          no_idle;
  int unsigned words_sent;
  int unsigned errors;
  int unsigned quiet_cycles;

  sha1_hash_engine_top uut (
    .clk          (clk),
    .rst          (rst),
    .data_word    (data_word),
    .valid_bytes  (valid_bytes),
    .last         (last),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .digest_word  (digest_word),
    .last_word    (last_word),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void clear_digest_state();
    chain_h[0] = INIT_H0;
    chain_h[1] = INIT_H1;
    chain_h[2] = INIT_H2;
    chain_h[3] = INIT_H3;
    chain_h[4] = INIT_H4;
    blk_fill = 0;
    msg_bytes = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = msg_blk[i];
    for (int i = 16; i < 80; i++) w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = ROUND_K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = ROUND_K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = ROUND_K2;
      end else begin
        f = b ^ c ^ d;
        k = ROUND_K3;
      end
      t = rol32(a, 5) + f + e + w[r] + k;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void absorb_word(input logic [31:0] v);
    msg_blk[blk_fill] = v;
    blk_fill = (blk_fill + 1) % 16;
    if (blk_fill == 0) compress_block();
  endfunction

  function automatic void predict_digest(input logic [31:0] w, input logic [2:0] nb,
                                         input logic lst);
    int unsigned   n;
    logic [31:0]   mask;
    logic [63:0]   bit_len;
    digest_entry_t ent;
    if (!lst) begin
      absorb_word(w);
      msg_bytes = msg_bytes + 61'd4;
      return;
    end
    n = (nb > FULL_WORD) ? FULL_WORD : nb;
    msg_bytes = msg_bytes + 61'(n);
    if (n == FULL_WORD) begin
      absorb_word(w);
      absorb_word({PAD_MARK, 24'h0});
    end else begin
      mask = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
      absorb_word((w & mask) | ({24'h0, PAD_MARK} << (8 * (3 - n))));
    end
    while (blk_fill != LENGTH_SLOT) absorb_word(32'h0);
    bit_len = {msg_bytes, 3'b000};
    absorb_word(bit_len[63:32]);
    absorb_word(bit_len[31:0]);
    for (int j = 0; j < 5; j++) begin
      ent.word = chain_h[j];
      ent.fin = (j == 4);
      digest_q.push_back(ent);
    end
    clear_digest_state();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %h got %h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
    if (!no_idle && $urandom_range(0, 99) < STALL_PCT) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    data_word <= w;
    valid_bytes <= nb;
    last <= lst;
    data_valid <= 1'b1;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    predict_digest(w, nb, lst);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned n_words, input logic [2:0] last_nb,
                              input bit odd_counts);
    logic [2:0] nb;
    for (int unsigned i = 1; i < n_words; i++) begin
      nb = (odd_counts && $urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : FULL_WORD;
      send_word($urandom, nb, 1'b0);
    end
    send_word($urandom, last_nb, 1'b1);
  endtask

  task automatic test_empty_message();
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    send_word($urandom, 3'd0, 1'b1);
  endtask

  task automatic test_partial_last_word();
    for (int n = 1; n < 4; n++) send_word(32'hffff_ffff, 3'(n), 1'b1);
  endtask

  task automatic test_count_saturation();
    for (int n = 5; n < 8; n++) send_word(32'h0000_0000, 3'(n), 1'b1);
  endtask

  task automatic test_short_inner_words();
    send_word(32'h1234_5678, 3'd1, 1'b0);
    send_word(32'hffff_ffff, 3'd0, 1'b0);
    send_word(32'h8765_4321, 3'd3, 1'b1);
  endtask

  task automatic test_padding_spill();
    send_message(LENGTH_SLOT, FULL_WORD, 1'b0);
  endtask

  task automatic test_back_to_back(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = words_sent + n_items;
    no_idle = 1'b1;
    while (words_sent < stop_at)
      send_message($urandom_range(1, 20), 3'($urandom_range(0, 7)), 1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_random_messages(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    stop_at = words_sent + n_items;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0)
        len = 16 * $urandom_range(0, 1) + $urandom_range(13, 17);
      else
        len = $urandom_range(1, 24);
      send_message(len, 3'($urandom_range(0, 7)), 1'b1);
    end
  endtask

  always @(negedge clk) begin
    digest_ready <= no_idle || ($urandom_range(0, 99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    digest_entry_t ent;
    if (!rst && digest_valid && digest_ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: digest word %h with nothing expected", $realtime, digest_word);
        errors++;
      end else begin
        ent = digest_q.pop_front();
        if (digest_word !== ent.word) report_mismatch("digest_word", ent.word, digest_word);
        if (last_word !== ent.fin) report_mismatch("last_word", 32'(ent.fin), 32'(last_word));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && data_ready) || (digest_valid && digest_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
      $display("sha1_hash_engine_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    data_word = '0;
    valid_bytes = '0;
    last = 1'b0;
    data_valid = 1'b0;
    digest_ready = 1'b0;
    no_idle = 1'b0;
    words_sent = 0;
    errors = 0;
    quiet_cycles = 0;
    clear_digest_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_message();
    test_partial_last_word();
    test_count_saturation();
    test_short_inner_words();
    test_padding_spill();
    test_back_to_back(100);
    test_random_messages(RANDOM_ITEMS - 100);
    data_valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("sha1_hash_engine_top test passed");
    else
      $display("sha1_hash_engine_top test failed");
    $finish;
  end

endmodule
